/* rtl/lfcd_pkg.sv */
// Package for the length-framed command deframer: frame marks, widths, cell control type.
// Used by lfcd_cell and length_framed_command_deframer_unit; depends on nothing.
package lfcd_pkg;

  localparam int unsigned BufferBytesDefault = 64;
  localparam int unsigned FrameOverhead      = 5;
  localparam int unsigned ByteW              = 8;
  // Wide enough for payload lengths up to 127, which covers the default 64-byte window.
  localparam int unsigned LenCntW            = 7;
  localparam int unsigned OutFieldW          = 6;
  localparam int unsigned OutDataW           = 32;

  localparam logic [ByteW-1:0] StartMark = 8'h3C;
  localparam logic [ByteW-1:0] EndMark   = 8'h3E;

  typedef struct packed {
    logic load;   // take the received byte
    logic shift;  // take the neighbor's byte (drop oldest)
  } lfcd_cell_ctl_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } lfcd_state_e;

endpackage

/* rtl/lfcd_cell.sv */
// One window cell of the deframer: a byte register that loads or takes its neighbor's byte.
// Depends on lfcd_pkg.
module lfcd_cell (
  input  logic                          clk_i,
  input  lfcd_pkg::lfcd_cell_ctl_t      ctl_i,
  input  logic [lfcd_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [lfcd_pkg::ByteW-1:0]    next_byte_i,
  output logic [lfcd_pkg::ByteW-1:0]    byte_o,
  output logic                          end_mark_o
);
  import lfcd_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.load) begin
      byte_d = rx_byte_i;
    end else if (ctl_i.shift) begin
      byte_d = next_byte_i;
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o     = byte_q;
  assign end_mark_o = (byte_q == EndMark);

endmodule

/* rtl/length_framed_command_deframer_unit.sv */
// Top level of the length-framed command deframer: window cell row, scan control, output register.
// Depends on lfcd_pkg and lfcd_cell.
//
// Usage: received link bytes enter one beat at a time on the s_axis channel (tdata[7:0]).
// A frame is '<', a command id, a 16-bit big-endian length, the payload and '>'.
// The bytes sit in a row of cells; dropping the oldest byte shifts every cell by one
// toward the head at once. After each byte the controller rescans: while the
// head is not a valid frame start it drops one byte per cycle. A byte is therefore
// accepted, then scanned with one drop per discarded byte, then given a final check.
// A byte that completes a frame also holds the input for each result beat and any
// receiver stall.
// s_axis_tready_o is high only while the controller is idle.
// On a complete frame the block emits one m_axis beat per payload byte (tlast on the
// final one), or one empty marker beat for a zero-length frame, and then clears the
// window. Emission reads the cell behind the header and shifts the row, one beat per
// cycle while the receiver takes them; a stall on m_axis_tready_i holds the output
// register and pauses emission. After the closing byte is accepted, the scan state drops
// any bytes before the frame and finds it, then the emit state loads the first result
// beat into the output register. A new byte may be accepted while the last result waits.
// Reset clears the fill count and the output valid; cell contents are not cleared,
// since only bytes below the fill count are ever looked at.
module length_framed_command_deframer_unit #(
  parameter int unsigned BUFFER_BYTES = lfcd_pkg::BufferBytesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [lfcd_pkg::ByteW-1:0]       s_axis_tdata_i,   // [7:0] rx_byte
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] frame_id, [13:8] frame_length, [14] has_data, [20:15] byte_index,
  // [28:21] payload_byte, [31:29] zero
  output logic [lfcd_pkg::OutDataW-1:0]    m_axis_tdata_o,
  output logic                             m_axis_tlast_o    // last
);
  import lfcd_pkg::*;

  localparam int unsigned FillW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned IdxW    = $clog2(BUFFER_BYTES);
  localparam int unsigned MaxLen  = BUFFER_BYTES - FrameOverhead;

  // Window cell row.
  lfcd_cell_ctl_t          cell_ctl [BUFFER_BYTES];
  logic [ByteW-1:0]        cell_byte [BUFFER_BYTES];
  logic [2**IdxW-1:0]      end_flags;

  // Control state.
  lfcd_state_e             state_q, state_d;
  logic [FillW-1:0]        fill_q, fill_d;
  logic [ByteW-1:0]        id_q, id_d;
  logic [LenCntW-1:0]      len_q, len_d;
  logic [LenCntW-1:0]      cnt_q, cnt_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [OutDataW-1:0]     out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;

  logic                    in_accept;
  logic                    full;
  logic                    shift_all;
  logic                    out_free;
  logic [15:0]             hdr_len;
  logic                    len_ok;
  logic                    body_short;
  logic [IdxW-1:0]         end_idx;
  logic                    emit_last;
  logic [LenCntW-1:0]      cnt_inc;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (fill_q == FillW'(BUFFER_BYTES));
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Header fields are read from fixed cells at the head of the row.
  assign hdr_len    = {cell_byte[2], cell_byte[3]};
  assign len_ok     = (hdr_len <= 16'(MaxLen));
  assign body_short = ({1'b0, hdr_len} + 17'(FrameOverhead)) > 17'(fill_q);
  // The closing byte sits at index length + 4, which is inside the row when len_ok holds.
  assign end_idx    = hdr_len[IdxW-1:0] + IdxW'(FrameOverhead - 1);
  assign cnt_inc    = cnt_q + LenCntW'(1);
  assign emit_last  = (len_q == '0) || (cnt_inc == len_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    id_d        = id_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    shift_all   = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          // A full window cannot occur after a scan; it would drop the oldest byte first.
          if (full) begin
            shift_all = 1'b1;
          end else begin
            fill_d = fill_q + FillW'(1);
          end
          state_d = StScan;
        end
      end
      StScan: begin
        if (fill_q == '0) begin
          state_d = StIdle;
        end else if (cell_byte[0] != StartMark) begin
          shift_all = 1'b1;
          fill_d    = fill_q - FillW'(1);
        end else if (fill_q < FillW'(FrameOverhead)) begin
          state_d = StIdle;
        end else if (!len_ok) begin
          shift_all = 1'b1;
          fill_d    = fill_q - FillW'(1);
        end else if (body_short) begin
          state_d = StIdle;
        end else if (!end_flags[end_idx]) begin
          shift_all = 1'b1;
          fill_d    = fill_q - FillW'(1);
        end else begin
          id_d    = cell_byte[1];
          len_d   = hdr_len[LenCntW-1:0];
          cnt_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = emit_last;
          out_data_d  = '0;
          out_data_d[7:0]   = id_q;
          if (len_q != '0) begin
            out_data_d[13:8]  = len_q[OutFieldW-1:0];
            out_data_d[14]    = 1'b1;
            out_data_d[20:15] = cnt_q[OutFieldW-1:0];
            out_data_d[28:21] = cell_byte[FrameOverhead-1];
            // Bring the next payload byte to the read cell.
            shift_all = 1'b1;
          end
          cnt_d = cnt_inc;
          if (emit_last) begin
            fill_d  = '0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Cell row: each cell takes its right neighbor's byte on a shift.
  for (genvar i = 0; i < BUFFER_BYTES; i++) begin : g_cell
    logic [ByteW-1:0] next_byte;

    if (i == BUFFER_BYTES - 1) begin : g_tail
      assign next_byte = '0;
    end else begin : g_mid
      assign next_byte = cell_byte[i+1];
    end

    assign cell_ctl[i].shift = shift_all;
    assign cell_ctl[i].load  = in_accept &&
                               (full ? (i == BUFFER_BYTES - 1) : (fill_q == FillW'(i)));

    lfcd_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl[i]),
      .rx_byte_i   (s_axis_tdata_i),
      .next_byte_i (next_byte),
      .byte_o      (cell_byte[i]),
      .end_mark_o  (end_flags[i])
    );
  end

  if (2**IdxW > BUFFER_BYTES) begin : g_pad
    assign end_flags[2**IdxW-1:BUFFER_BYTES] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    len_q      <= len_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // The scan never leaves a full window behind.
  a_idle_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (fill_q < FillW'(BUFFER_BYTES)))
    else $error("window full while idle");

  // During emission the whole frame is inside the window.
  a_emit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> ((8'(len_q) + 8'(FrameOverhead)) <= 8'(fill_q)))
    else $error("emitting a frame longer than the window contents");

  // Every accepted byte is followed by a scan.
  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StScan))
    else $error("accepted byte not scanned");

  // The emission counter stays within the latched payload length.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && len_q != '0) |-> (cnt_q < len_q))
    else $error("payload index beyond frame length");

endmodule
